// File: rtl/frpt_pkg.sv
// Package for the prime-table fraction reducer.
// Holds the request and result payload types, the sequencer state type,
// sizing constants and the constant table of the first 500 primes.
package frpt_pkg;

    localparam int FIELD_BITS        = 16;
    localparam int VALUE_BITS_DEF    = 16;
    localparam int PRIME_COUNT_DEF   = 500;
    localparam int PRIME_TABLE_SIZE  = 500;
    localparam int PRIME_BITS        = 12;
    localparam int ROM_IDX_BITS      = 9;

    typedef struct packed {
        logic [FIELD_BITS-1:0] numerator;
        logic [FIELD_BITS-1:0] denominator;
    } frpt_in_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] reduced_numerator;
        logic [FIELD_BITS-1:0] reduced_denominator;
    } frpt_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CHECK,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_EMIT
    } frpt_state_t;

    localparam logic [PRIME_BITS-1:0] PRIME_ROM [0:PRIME_TABLE_SIZE-1] = '{
        12'd2, 12'd3, 12'd5, 12'd7, 12'd11, 12'd13, 12'd17, 12'd19, 12'd23, 12'd29,
        12'd31, 12'd37, 12'd41, 12'd43, 12'd47, 12'd53, 12'd59, 12'd61, 12'd67, 12'd71,
        12'd73, 12'd79, 12'd83, 12'd89, 12'd97, 12'd101, 12'd103, 12'd107, 12'd109,
        12'd113, 12'd127, 12'd131, 12'd137, 12'd139, 12'd149, 12'd151, 12'd157,
        12'd163, 12'd167, 12'd173, 12'd179, 12'd181, 12'd191, 12'd193, 12'd197,
        12'd199, 12'd211, 12'd223, 12'd227, 12'd229, 12'd233, 12'd239, 12'd241,
        12'd251, 12'd257, 12'd263, 12'd269, 12'd271, 12'd277, 12'd281, 12'd283,
        12'd293, 12'd307, 12'd311, 12'd313, 12'd317, 12'd331, 12'd337, 12'd347,
        12'd349, 12'd353, 12'd359, 12'd367, 12'd373, 12'd379, 12'd383, 12'd389,
        12'd397, 12'd401, 12'd409, 12'd419, 12'd421, 12'd431, 12'd433, 12'd439,
        12'd443, 12'd449, 12'd457, 12'd461, 12'd463, 12'd467, 12'd479, 12'd487,
        12'd491, 12'd499, 12'd503, 12'd509, 12'd521, 12'd523, 12'd541, 12'd547,
        12'd557, 12'd563, 12'd569, 12'd571, 12'd577, 12'd587, 12'd593, 12'd599,
        12'd601, 12'd607, 12'd613, 12'd617, 12'd619, 12'd631, 12'd641, 12'd643,
        12'd647, 12'd653, 12'd659, 12'd661, 12'd673, 12'd677, 12'd683, 12'd691,
        12'd701, 12'd709, 12'd719, 12'd727, 12'd733, 12'd739, 12'd743, 12'd751,
        12'd757, 12'd761, 12'd769, 12'd773, 12'd787, 12'd797, 12'd809, 12'd811,
        12'd821, 12'd823, 12'd827, 12'd829, 12'd839, 12'd853, 12'd857, 12'd859,
        12'd863, 12'd877, 12'd881, 12'd883, 12'd887, 12'd907, 12'd911, 12'd919,
        12'd929, 12'd937, 12'd941, 12'd947, 12'd953, 12'd967, 12'd971, 12'd977,
        12'd983, 12'd991, 12'd997, 12'd1009, 12'd1013, 12'd1019, 12'd1021, 12'd1031,
        12'd1033, 12'd1039, 12'd1049, 12'd1051, 12'd1061, 12'd1063, 12'd1069,
        12'd1087, 12'd1091, 12'd1093, 12'd1097, 12'd1103, 12'd1109, 12'd1117,
        12'd1123, 12'd1129, 12'd1151, 12'd1153, 12'd1163, 12'd1171, 12'd1181,
        12'd1187, 12'd1193, 12'd1201, 12'd1213, 12'd1217, 12'd1223, 12'd1229,
        12'd1231, 12'd1237, 12'd1249, 12'd1259, 12'd1277, 12'd1279, 12'd1283,
        12'd1289, 12'd1291, 12'd1297, 12'd1301, 12'd1303, 12'd1307, 12'd1319,
        12'd1321, 12'd1327, 12'd1361, 12'd1367, 12'd1373, 12'd1381, 12'd1399,
        12'd1409, 12'd1423, 12'd1427, 12'd1429, 12'd1433, 12'd1439, 12'd1447,
        12'd1451, 12'd1453, 12'd1459, 12'd1471, 12'd1481, 12'd1483, 12'd1487,
        12'd1489, 12'd1493, 12'd1499, 12'd1511, 12'd1523, 12'd1531, 12'd1543,
        12'd1549, 12'd1553, 12'd1559, 12'd1567, 12'd1571, 12'd1579, 12'd1583,
        12'd1597, 12'd1601, 12'd1607, 12'd1609, 12'd1613, 12'd1619, 12'd1621,
        12'd1627, 12'd1637, 12'd1657, 12'd1663, 12'd1667, 12'd1669, 12'd1693,
        12'd1697, 12'd1699, 12'd1709, 12'd1721, 12'd1723, 12'd1733, 12'd1741,
        12'd1747, 12'd1753, 12'd1759, 12'd1777, 12'd1783, 12'd1787, 12'd1789,
        12'd1801, 12'd1811, 12'd1823, 12'd1831, 12'd1847, 12'd1861, 12'd1867,
        12'd1871, 12'd1873, 12'd1877, 12'd1879, 12'd1889, 12'd1901, 12'd1907,
        12'd1913, 12'd1931, 12'd1933, 12'd1949, 12'd1951, 12'd1973, 12'd1979,
        12'd1987, 12'd1993, 12'd1997, 12'd1999, 12'd2003, 12'd2011, 12'd2017,
        12'd2027, 12'd2029, 12'd2039, 12'd2053, 12'd2063, 12'd2069, 12'd2081,
        12'd2083, 12'd2087, 12'd2089, 12'd2099, 12'd2111, 12'd2113, 12'd2129,
        12'd2131, 12'd2137, 12'd2141, 12'd2143, 12'd2153, 12'd2161, 12'd2179,
        12'd2203, 12'd2207, 12'd2213, 12'd2221, 12'd2237, 12'd2239, 12'd2243,
        12'd2251, 12'd2267, 12'd2269, 12'd2273, 12'd2281, 12'd2287, 12'd2293,
        12'd2297, 12'd2309, 12'd2311, 12'd2333, 12'd2339, 12'd2341, 12'd2347,
        12'd2351, 12'd2357, 12'd2371, 12'd2377, 12'd2381, 12'd2383, 12'd2389,
        12'd2393, 12'd2399, 12'd2411, 12'd2417, 12'd2423, 12'd2437, 12'd2441,
        12'd2447, 12'd2459, 12'd2467, 12'd2473, 12'd2477, 12'd2503, 12'd2521,
        12'd2531, 12'd2539, 12'd2543, 12'd2549, 12'd2551, 12'd2557, 12'd2579,
        12'd2591, 12'd2593, 12'd2609, 12'd2617, 12'd2621, 12'd2633, 12'd2647,
        12'd2657, 12'd2659, 12'd2663, 12'd2671, 12'd2677, 12'd2683, 12'd2687,
        12'd2689, 12'd2693, 12'd2699, 12'd2707, 12'd2711, 12'd2713, 12'd2719,
        12'd2729, 12'd2731, 12'd2741, 12'd2749, 12'd2753, 12'd2767, 12'd2777,
        12'd2789, 12'd2791, 12'd2797, 12'd2801, 12'd2803, 12'd2819, 12'd2833,
        12'd2837, 12'd2843, 12'd2851, 12'd2857, 12'd2861, 12'd2879, 12'd2887,
        12'd2897, 12'd2903, 12'd2909, 12'd2917, 12'd2927, 12'd2939, 12'd2953,
        12'd2957, 12'd2963, 12'd2969, 12'd2971, 12'd2999, 12'd3001, 12'd3011,
        12'd3019, 12'd3023, 12'd3037, 12'd3041, 12'd3049, 12'd3061, 12'd3067,
        12'd3079, 12'd3083, 12'd3089, 12'd3109, 12'd3119, 12'd3121, 12'd3137,
        12'd3163, 12'd3167, 12'd3169, 12'd3181, 12'd3187, 12'd3191, 12'd3203,
        12'd3209, 12'd3217, 12'd3221, 12'd3229, 12'd3251, 12'd3253, 12'd3257,
        12'd3259, 12'd3271, 12'd3299, 12'd3301, 12'd3307, 12'd3313, 12'd3319,
        12'd3323, 12'd3329, 12'd3331, 12'd3343, 12'd3347, 12'd3359, 12'd3361,
        12'd3371, 12'd3373, 12'd3389, 12'd3391, 12'd3407, 12'd3413, 12'd3433,
        12'd3449, 12'd3457, 12'd3461, 12'd3463, 12'd3467, 12'd3469, 12'd3491,
        12'd3499, 12'd3511, 12'd3517, 12'd3527, 12'd3529, 12'd3533, 12'd3539,
        12'd3541, 12'd3547, 12'd3557, 12'd3559, 12'd3571
    };

    function automatic logic [PRIME_BITS-1:0] prime_at(input logic [ROM_IDX_BITS-1:0] idx);
        logic [PRIME_BITS-1:0] p;
        p = PRIME_ROM[0];
        if (int'(idx) < PRIME_TABLE_SIZE) begin
            p = PRIME_ROM[idx];
        end
        return p;
    endfunction

endpackage

// File: rtl/frpt_div.sv
// Bit-serial restoring divider shared by the fraction reducer sequencer.
// Divides a VALUE_BITS dividend by a table prime, one quotient bit per cycle.
// Depends on frpt_pkg for the prime width.
module frpt_div
    import frpt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [PRIME_BITS-1:0] divisor,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [PRIME_BITS-1:0] remainder
);

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [PRIME_BITS-1:0] rem_reg, rem_next;
    logic [PRIME_BITS-1:0] divisor_reg, divisor_next;
    logic [PRIME_BITS:0]   trial;
    logic [PRIME_BITS:0]   diff;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start) begin
            busy_next    = 1'b1;
            cnt_next     = CNT_BITS'(VALUE_BITS);
            quo_next     = dividend;
            rem_next     = '0;
            divisor_next = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[VALUE_BITS-2:0], fits};
            rem_next = fits ? diff[PRIME_BITS-1:0] : trial[PRIME_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("Divider started while busy.");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (rem_reg < divisor_reg))
        else $error("Divider remainder not below divisor.");

    a_done_after_count: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (cnt_reg == '0) && !busy_reg)
        else $error("Divider finished before all quotient bits.");
`endif

endmodule

// File: rtl/fraction_reduce_prime_table.sv
// Fraction reducer: removes the common factors of a numerator and a
// denominator that are among the first PRIME_COUNT (default 500) table primes.
//
// Usage: a request (numerator, denominator) enters on s_valid/s_ready/s_data;
// one result leaves on m_valid/m_ready/m_data for every request. s_ready is
// high only while the sequencer is idle, so requests are handled one at a time.
// The sequencer walks the prime table from the largest entry down, fetching
// and checking each entry and skipping it when the prime exceeds either value.
// When a prime is not larger, the shared bit-serial divider tests it against
// the numerator and, when that divides, the denominator; a prime that divides
// both is divided out and tried again. A zero or one value makes every prime
// skip, so such a request only walks the table.
// Results wait in an output register: the next request is accepted while a
// result stalls, but a new result is held back until the old one is taken.
// Reset (aresetn, synchronous, active low) empties the output register and
// returns the sequencer to idle.
module fraction_reduce_prime_table
    import frpt_pkg::*;
#(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int PRIME_COUNT = PRIME_COUNT_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  frpt_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output frpt_out_t m_data
);

    localparam int IDX_BITS = (PRIME_COUNT > 1) ? $clog2(PRIME_COUNT) : 1;
    localparam int CMP_BITS = (VALUE_BITS > PRIME_BITS) ? VALUE_BITS : PRIME_BITS;

    frpt_state_t           state_reg, state_next;
    logic [IDX_BITS-1:0]   idx_reg, idx_next;
    logic [VALUE_BITS-1:0] num_reg, num_next;
    logic [VALUE_BITS-1:0] den_reg, den_next;
    logic [VALUE_BITS-1:0] qnum_reg, qnum_next;
    logic [PRIME_BITS-1:0] prime_reg, prime_next;
    logic                  m_valid_reg, m_valid_next;
    frpt_out_t             m_data_reg, m_data_next;

    logic                  accept;
    logic                  skip;
    logic                  last_prime;
    logic                  out_free;
    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quo;
    logic [PRIME_BITS-1:0] div_rem;

    assign accept     = s_valid && s_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign skip       = (CMP_BITS'(num_reg) < CMP_BITS'(prime_reg))
                     || (CMP_BITS'(den_reg) < CMP_BITS'(prime_reg));
    assign last_prime = (idx_reg == '0);
    assign out_free   = !m_valid_reg || m_ready;
    assign prime_next = prime_at(ROM_IDX_BITS'(idx_reg));

    frpt_div #(
        .VALUE_BITS(VALUE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (prime_reg),
        .done     (div_done),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!skip) begin
                    state_next = ST_DIV_NUM;
                end else if (last_prime) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_FETCH;
                end
            end
            ST_DIV_NUM: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        state_next = ST_DIV_DEN;
                    end else if (last_prime) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_DIV_DEN: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        state_next = ST_CHECK;
                    end else if (last_prime) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        idx_next     = idx_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        qnum_next    = qnum_reg;
        div_start    = 1'b0;
        div_dividend = num_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    num_next = VALUE_BITS'(s_data.numerator);
                    den_next = VALUE_BITS'(s_data.denominator);
                    idx_next = IDX_BITS'(PRIME_COUNT - 1);
                end
            end
            ST_CHECK: begin
                if (!skip) begin
                    div_start = 1'b1;
                end else if (!last_prime) begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_DIV_NUM: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        qnum_next    = div_quo;
                        div_start    = 1'b1;
                        div_dividend = den_reg;
                    end else if (!last_prime) begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            ST_DIV_DEN: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        num_next = qnum_reg;
                        den_next = div_quo;
                    end else if (!last_prime) begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next.reduced_numerator   = FIELD_BITS'(num_reg);
                    m_data_next.reduced_denominator = FIELD_BITS'(den_reg);
                end
            end
            default: begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        qnum_reg   <= qnum_next;
        prime_reg  <= prime_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV_NUM) || (state_reg == ST_DIV_DEN))
        else $error("Divider result arrived outside a division state.");

    a_values_shrink: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |=> (num_reg <= $past(num_reg)) && (den_reg <= $past(den_reg)))
        else $error("A value grew during reduction.");

    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("Result loaded outside the emit state.");
`endif

endmodule
